>>> hw/rtl/q2e_pkg.sv
// Shared package for the quaternion to Z-Y-X Euler angle converter.
// Holds the datapath widths, angle constants, the CORDIC arctangent table
// and the output rounding function. Depends on nothing.
package q2e_pkg;

  // default CORDIC iteration count and its upper limit (table size)
  localparam int CordicStepsDef = 16;
  localparam int MaxSteps       = 24;

  // CORDIC x/y width and angle width (angles in Q.24 radians)
  localparam int XW = 37;
  localparam int ZW = 29;
  localparam int AW = 31;  // wide angle after lock-path doubling

  // integer square root: 31 bit-pairs over a 61-bit radicand
  localparam int SqSteps = 31;
  localparam int VW      = 61;
  localparam int RW      = 62;

  localparam logic signed [ZW-1:0] AngPi     = ZW'(52707179);
  localparam logic signed [ZW-1:0] AngHalfPi = ZW'(26353589);
  localparam logic signed [AW-1:0] AngTwoPi  = AW'(105414358);
  localparam logic [14:0] OutPi     = 15'd25736;
  localparam logic [14:0] OutHalfPi = 15'd12868;

  // dead band around zero for the lock path sign decision (Q2.30)
  localparam logic signed [33:0] NegEps = 34'sd10737;
  localparam logic signed [33:0] PosEps = 34'sd1074;

  localparam logic [14:0] LockThrRst = 15'd16352;

  // flags that travel beside the angle datapath
  typedef struct packed {
    logic lock;
    logic neg;
    logic pos;
  } q2e_side_t;

  // arctangent of 2^-i in Q.24
  function automatic logic signed [ZW-1:0] atan_angle(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(13176795);
      1:  r = ZW'(7778716);
      2:  r = ZW'(4110060);
      3:  r = ZW'(2086331);
      4:  r = ZW'(1047214);
      5:  r = ZW'(524117);
      6:  r = ZW'(262123);
      7:  r = ZW'(131069);
      8:  r = ZW'(65536);
      9:  r = ZW'(32768);
      10: r = ZW'(16384);
      11: r = ZW'(8192);
      12: r = ZW'(4096);
      13: r = ZW'(2048);
      14: r = ZW'(1024);
      15: r = ZW'(512);
      16: r = ZW'(256);
      17: r = ZW'(128);
      18: r = ZW'(64);
      19: r = ZW'(32);
      20: r = ZW'(16);
      21: r = ZW'(8);
      22: r = ZW'(4);
      23: r = ZW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q.24 to Q3.13, round half away from zero, then clamp to +-lim
  function automatic logic signed [15:0] to_q13(input logic signed [AW-1:0] a,
                                                input logic [14:0] lim);
    logic [AW-1:0] mag;
    logic [AW-1:0] rnd;
    logic [19:0]   r;
    logic [14:0]   rc;
    mag = a[AW-1] ? AW'(-a) : AW'(a);
    rnd = mag + AW'(1024);
    r   = rnd[AW-1:11];
    rc  = (r > 20'(lim)) ? lim : r[14:0];
    return a[AW-1] ? -$signed({1'b0, rc}) : $signed({1'b0, rc});
  endfunction

endpackage

>>> hw/rtl/q2e_delay.sv
// Enabled shift line for payload that must keep pace with the pipeline.
// Uses no package items.
module q2e_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  // shift one place per advancing cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

>>> hw/rtl/q2e_sqrt_cell.sv
// One bit-pair step of the restoring integer square root.
// Depends on q2e_pkg for the radicand and root widths.
module q2e_sqrt_cell
  import q2e_pkg::*;
#(
  parameter int K = 0  // this cell tests the bit pair at 4^K
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [VW-1:0] v_i,
  input  logic [RW-1:0] res_i,
  output logic [VW-1:0] v_o,
  output logic [RW-1:0] res_o
);

  localparam logic [RW:0] One = (RW+1)'(1) << (2 * K);

  logic [RW:0]   trial;
  logic          take;
  logic [VW-1:0] v_d;
  logic [RW-1:0] res_d;
  logic [VW-1:0] v_q;
  logic [RW-1:0] res_q;

  // compare remainder with root plus the current bit pair
  always_comb begin
    trial = {1'b0, res_i} + One;
    take  = ({{(RW+1-VW){1'b0}}, v_i} >= trial);
    if (take) begin
      v_d   = v_i - trial[VW-1:0];
      res_d = (res_i >> 1) + One[RW-1:0];
    end else begin
      v_d   = v_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q   <= v_d;
      res_q <= res_d;
    end
  end

  assign v_o   = v_q;
  assign res_o = res_q;

endmodule

>>> hw/rtl/q2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation with a fixed shift.
// Depends on q2e_pkg for widths and the arctangent table.
module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic                 zero_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic                 zero_o
);

  localparam logic signed [ZW-1:0] Step = atan_angle(SHIFT);

  logic signed [XW-1:0] xs, ys, x_d, y_d;
  logic signed [ZW-1:0] z_d;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic                 zero_q;

  // rotate towards the x axis
  always_comb begin
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    if (!y_i[XW-1] && (y_i != '0)) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Step;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= zero_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign zero_o = zero_q;

endmodule

>>> hw/rtl/q2e_atan2.sv
// Pipelined atan2: a half-plane fold stage then a row of CORDIC cells.
// Depends on q2e_pkg and q2e_cordic_cell. Every stage is registered.
module q2e_atan2
  import q2e_pkg::*;
#(
  parameter int STEPS = CordicStepsDef
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [XW-1:0] x_i,
  output logic signed [ZW-1:0] z_o,
  output logic                 zero_o
);

  logic signed [XW-1:0] x_c [STEPS+1];
  logic signed [XW-1:0] y_c [STEPS+1];
  logic signed [ZW-1:0] z_c [STEPS+1];
  logic                 zero_c [STEPS+1];

  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic                 zero_q;

  // fold the left half-plane onto the right one, flag the origin
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      if (x_i[XW-1]) begin
        x_q <= -x_i;
        y_q <= -y_i;
        z_q <= y_i[XW-1] ? -AngPi : AngPi;
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end
  end

  assign x_c[0]    = x_q;
  assign y_c[0]    = y_q;
  assign z_c[0]    = z_q;
  assign zero_c[0] = zero_q;

  // row of micro-rotation cells
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    q2e_cordic_cell #(.SHIFT(i)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .x_i    (x_c[i]),
      .y_i    (y_c[i]),
      .z_i    (z_c[i]),
      .zero_i (zero_c[i]),
      .x_o    (x_c[i+1]),
      .y_o    (y_c[i+1]),
      .z_o    (z_c[i+1]),
      .zero_o (zero_c[i+1])
    );
  end

  assign z_o    = z_c[STEPS];
  assign zero_o = zero_c[STEPS];

endmodule

>>> hw/rtl/quaternion_to_euler_zyx.sv
// Quaternion (Q1.15) to Z-Y-X Euler angles (Q3.13 radians), fully pipelined.
// Depends on q2e_pkg, q2e_delay, q2e_sqrt_cell and q2e_atan2.
//
// One quaternion is taken every cycle while the output side keeps up; the
// pipe holds the input register, product stage, sum and lock decision,
// radicand stage, 31 square-root cells, fold stage, CORDIC cells and the
// output register. The whole pipe advances together, so it halts only
// while a result sits in the output register and is not taken. lock_threshold
// may be written only while the pipe is empty.
module quaternion_to_euler_zyx
  import q2e_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef  // 8 .. 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,   // lock_threshold
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // qw, qx, qy, qz
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // roll, pitch, yaw, zero pad
  output logic        m_axis_tuser   // gimbal_lock
);

  localparam int SqLat  = SqSteps + 1;
  localparam int VldLen = 3 + SqLat + 1 + CORDIC_STEPS;

  logic        en;
  logic [14:0] lock_threshold_q;
  logic [VldLen-1:0] vld_q;
  logic        out_valid_q;

  assign en            = m_axis_tready || !out_valid_q;
  assign s_axis_tready = en;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_threshold_q <= LockThrRst;
    end else if (cfg_we_i) begin
      lock_threshold_q <= cfg_wdata_i;
    end
  end

  // valid marks along the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[VldLen-2:0], s_axis_tvalid};
      out_valid_q <= vld_q[VldLen-1];
    end
  end

  // input register
  logic signed [15:0] w_q, x_q, y_q, z_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q <= s_axis_tdata[15:0];
      x_q <= s_axis_tdata[31:16];
      y_q <= s_axis_tdata[47:32];
      z_q <= s_axis_tdata[63:48];
    end
  end

  // products
  logic signed [31:0] p_wy_q, p_xz_q, p_yz_q, p_wx_q, p_xy_q, p_wz_q;
  logic signed [31:0] p_ww_q, p_xx_q, p_yy_q, p_zz_q;
  logic signed [15:0] w2_q, x2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wy_q <= w_q * y_q;
      p_xz_q <= x_q * z_q;
      p_yz_q <= y_q * z_q;
      p_wx_q <= w_q * x_q;
      p_xy_q <= x_q * y_q;
      p_wz_q <= w_q * z_q;
      p_ww_q <= w_q * w_q;
      p_xx_q <= x_q * x_q;
      p_yy_q <= y_q * y_q;
      p_zz_q <= z_q * z_q;
      w2_q   <= w_q;
      x2_q   <= x_q;
    end
  end

  // sums, singularity term and lock decision
  logic signed [33:0] s_t, s2_t, thr_t, ry_t, rx_t, yy_t, yx_t;
  logic signed [31:0] a_t;
  q2e_side_t          side_t;
  logic signed [XW-1:0] ry_d, rx_d, yy_d, yx_d;
  always_comb begin
    s_t   = 34'(p_wy_q) - 34'(p_xz_q);
    s2_t  = s_t <<< 1;
    thr_t = $signed({4'b0, lock_threshold_q, 15'b0});
    ry_t  = (34'(p_yz_q) + 34'(p_wx_q)) <<< 1;
    rx_t  = 34'(p_ww_q) - 34'(p_xx_q) - 34'(p_yy_q) + 34'(p_zz_q);
    yy_t  = (34'(p_xy_q) + 34'(p_wz_q)) <<< 1;
    yx_t  = 34'(p_ww_q) + 34'(p_xx_q) - 34'(p_yy_q) - 34'(p_zz_q);
    side_t.lock = (s_t < -thr_t) || (s_t > thr_t);
    side_t.neg  = s_t < -NegEps;
    side_t.pos  = s_t > PosEps;
    if (s2_t > 34'sd1073741824) begin
      a_t = 32'sd1073741824;
    end else if (s2_t < -34'sd1073741824) begin
      a_t = -32'sd1073741824;
    end else begin
      a_t = s2_t[31:0];
    end
    ry_d = XW'(ry_t);
    rx_d = XW'(rx_t);
    // the lock path reuses the yaw unit for atan2(x, w)
    if (side_t.lock) begin
      yy_d = XW'(x2_q) <<< 15;
      yx_d = XW'(w2_q) <<< 15;
    end else begin
      yy_d = XW'(yy_t);
      yx_d = XW'(yx_t);
    end
  end

  logic signed [XW-1:0] ry_q, rx_q, yy_q, yx_q;
  logic signed [31:0]   a_q;
  q2e_side_t            side_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ry_q   <= ry_d;
      rx_q   <= rx_d;
      yy_q   <= yy_d;
      yx_q   <= yx_d;
      a_q    <= a_t;
      side_q <= side_t;
    end
  end

  // radicand 1 - a^2 in Q.60
  logic signed [63:0] sq_t;
  logic [VW-1:0]      v0_q;
  assign sq_t = a_q * a_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      v0_q <= (VW'(1) << 60) - sq_t[VW-1:0];
    end
  end

  // square-root cells
  logic [VW-1:0] v_c [SqSteps+1];
  logic [RW-1:0] r_c [SqSteps+1];
  assign v_c[0] = v0_q;
  assign r_c[0] = '0;
  for (genvar i = 0; i < SqSteps; i++) begin : g_sqrt
    q2e_sqrt_cell #(.K(SqSteps - 1 - i)) u_sq (
      .clk_i (clk_i),
      .en_i  (en),
      .v_i   (v_c[i]),
      .res_i (r_c[i]),
      .v_o   (v_c[i+1]),
      .res_o (r_c[i+1])
    );
  end

  // align roll and yaw operands and the asin argument with the root
  logic [4*XW+32-1:0] ops_d;
  logic [4*XW+32-1:0] ops_q;
  assign ops_d = {ry_q, rx_q, yy_q, yx_q, a_q};
  q2e_delay #(.WIDTH(4*XW+32), .DEPTH(SqLat)) u_ops_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (ops_d),
    .q_o   (ops_q)
  );

  q2e_side_t side_dq;
  q2e_delay #(.WIDTH($bits(q2e_side_t)), .DEPTH(SqLat + 1 + CORDIC_STEPS)) u_side_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side_q),
    .q_o   (side_dq)
  );

  logic signed [XW-1:0] ry_a, rx_a, yy_a, yx_a, py_a, px_a;
  assign ry_a = ops_q[4*XW+31 -: XW];
  assign rx_a = ops_q[3*XW+31 -: XW];
  assign yy_a = ops_q[2*XW+31 -: XW];
  assign yx_a = ops_q[XW+31 -: XW];
  assign py_a = XW'($signed(ops_q[31:0]));
  assign px_a = $signed({{(XW-31){1'b0}}, r_c[SqSteps][30:0]});

  // three atan2 units
  logic signed [ZW-1:0] zr, zp, zy;
  logic                 nr, np, ny;
  q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk_i (clk_i), .en_i (en), .y_i (ry_a), .x_i (rx_a), .z_o (zr), .zero_o (nr)
  );
  q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i (clk_i), .en_i (en), .y_i (py_a), .x_i (px_a), .z_o (zp), .zero_o (np)
  );
  q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk_i (clk_i), .en_i (en), .y_i (yy_a), .x_i (yx_a), .z_o (zy), .zero_o (ny)
  );

  // lock-path selection, yaw wrap, rounding to Q3.13
  logic signed [AW-1:0] roll_a, pitch_a, yaw_a, yz_a;
  logic signed [15:0]   roll_r, pitch_r, yaw_r;
  always_comb begin
    roll_a  = nr ? '0 : AW'(zr);
    pitch_a = np ? '0 : AW'(zp);
    yz_a    = ny ? '0 : AW'(zy);
    yaw_a   = yz_a;
    if (side_dq.lock) begin
      roll_a = '0;
      if (side_dq.neg) begin
        yaw_a   = yz_a <<< 1;
        pitch_a = -AW'(AngHalfPi);
      end else if (side_dq.pos) begin
        yaw_a   = -(yz_a <<< 1);
        pitch_a = AW'(AngHalfPi);
      end else begin
        yaw_a   = '0;
        pitch_a = '0;
      end
      if (yaw_a > AW'(AngPi)) begin
        yaw_a = yaw_a - AngTwoPi;
      end else if (yaw_a < -AW'(AngPi)) begin
        yaw_a = yaw_a + AngTwoPi;
      end
    end
    roll_r  = to_q13(roll_a, OutPi);
    pitch_r = to_q13(pitch_a, OutHalfPi);
    yaw_r   = to_q13(yaw_a, OutPi);
  end

  // output register
  logic [46:0] out_data_q;
  logic        out_lock_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {yaw_r, pitch_r[14:0], roll_r};
      out_lock_q <= side_dq.lock;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};
  assign m_axis_tuser  = out_lock_q;

  // the lock path always reports zero roll
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("roll not zero on gimbal lock");

  // pitch never leaves +-pi/2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= 15'sd12868 &&
                       $signed(m_axis_tdata[30:16]) >= -15'sd12868))
    else $error("pitch out of range");

  // a fresh result comes only from the last pipe stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[VldLen-1]))
    else $error("result without an item in the pipe");

endmodule

>>> sim/quaternion_to_euler_zyx_test.sv
// Testbench for the quaternion to Z-Y-X Euler angle converter.
// Directed table then random quaternions, checked against a behavioural
// predictor with random idling on both streams. Depends on q2e_pkg and the RTL.
module quaternion_to_euler_zyx_test;
  import q2e_pkg::*;

  localparam int Steps    = CordicStepsDef;
  localparam int Latency  = Steps + 37;
  localparam int NRandom  = 1330;
  localparam longint CycleLimit = 2000000;

  // output tdata: roll, pitch, yaw, zero pad; tuser: gimbal lock
  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic               lock;
  } angles_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    logic               set_thr;  // write threshold before this row
    logic [14:0]        thr;
    logic               has_exp;  // row carries a typed-in result
    angles_t            exp;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic [14:0] lock_thr;
  angles_t     angles_q[$];
  int          errors = 0;
  longint      cycles = 0;
  int          rx_wait = 0;

  quaternion_to_euler_zyx #(.CORDIC_STEPS(Steps)) u_dut (.*);

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  // vectoring cordic, angle in Q.24
  function automatic longint atan2_q24(longint y, longint x);
    longint a, xs, ys;
    int     n;
    a = 0;
    n = (Steps > MaxSteps) ? MaxSteps : Steps;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      a = (y >= 0) ? 52707179 : -52707179;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < n; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; a += longint'(atan_angle(i));
      end else begin
        x = x - ys; y = y + xs; a -= longint'(atan_angle(i));
      end
    end
    return a;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = (a >= 0) ? ((a + 1024) >>> 11) : -((-a + 1024) >>> 11);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
                                       logic signed [15:0] qy, logic signed [15:0] qz);
    longint  w, x, y, z, s, thr, r, p, yw, a;
    angles_t o;
    w = qw; x = qx; y = qy; z = qz;
    s = w * y - x * z;
    thr = longint'(lock_thr) * 32768;
    r = 0; p = 0; yw = 0;
    o.lock = 1'b0;
    if (s < -thr || s > thr) begin
      o.lock = 1'b1;
      if (s < -10737) begin
        yw = 2 * atan2_q24(x * 32768, w * 32768);
        p = -26353589;
      end else if (s > 1074) begin
        yw = -2 * atan2_q24(x * 32768, w * 32768);
        p = 26353589;
      end
      if (yw > 52707179) yw -= 105414358;
      if (yw < -52707179) yw += 105414358;
    end else begin
      a = 2 * s;
      r = atan2_q24(2 * (y * z + w * x), w * w - x * x - y * y + z * z);
      yw = atan2_q24(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
      if (a > 64'sd1073741824) a = 64'sd1073741824;
      if (a < -64'sd1073741824) a = -64'sd1073741824;
      p = atan2_q24(a, root_floor(longint'(64'd1 << 60) - a * a));
    end
    o.roll  = 16'(round_q13(r, 25736));
    o.pitch = 15'(round_q13(p, 12868));
    o.yaw   = 16'(round_q13(yw, 25736));
    return o;
  endfunction

  task automatic write_threshold(logic [14:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lock_thr = v;
  endtask

  task automatic wait_drained();
    while (angles_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // one transfer on the input stream, with a random gap first if gaps is set
  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z, bit gaps);
    int gap;
    gap = gaps ? int'($urandom_range(19)) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x, w};
    angles_q.insert(angles_q.size(), euler_of(w, x, y, z));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // receiver with a random wait per transfer; burst mode waits not at all
  always @(posedge clk_i) begin
    angles_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[46:0], m_axis_tuser};
        if (angles_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer %h", $time, got);
        end else begin
          want = angles_q.pop_front();
          if (got.roll !== want.roll || got.pitch !== want.pitch ||
              got.yaw !== want.yaw || got.lock !== want.lock) begin
            errors++;
            $display("%0t: expected r=%0d p=%0d y=%0d l=%0b got r=%0d p=%0d y=%0d l=%0b",
                     $time, want.roll, want.pitch, want.yaw, want.lock,
                     got.roll, got.pitch, got.yaw, got.lock);
          end
        end
        if (m_axis_tdata[47] !== 1'b0) begin
          errors++;
          $display("%0t: expected pad 0 got %b", $time, m_axis_tdata[47]);
        end
        rx_wait = (cycles % 4000 < 800) ? 0 : int'($urandom_range(19));
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      m_axis_tready <= (rx_wait == 0);
    end
  end

  stim_row_t rows[$];

  function automatic void append_row(stim_row_t t);
    rows.insert(rows.size(), t);
  endfunction

  function automatic stim_row_t mk(int w, int x, int y, int z);
    stim_row_t t;
    t.w = 16'(w); t.x = 16'(x); t.y = 16'(y); t.z = 16'(z);
    t.set_thr = 0; t.thr = 0; t.has_exp = 0; t.exp = '0;
    return t;
  endfunction

  initial begin
    stim_row_t t;
    int ph;
    logic signed [15:0] w, x, y, z;
    // identity, all zero, extremes
    t = mk(32767, 0, 0, 0); t.has_exp = 1; t.exp = '0; append_row(t);
    t = mk(0, 0, 0, 0); t.has_exp = 1; t.exp = '0; append_row(t);
    append_row(mk(-32768, -32768, -32768, -32768));
    append_row(mk(32767, 32767, 32767, 32767));
    append_row(mk(-32768, 0, 0, 0));
    append_row(mk(0, 32767, 0, 0));
    append_row(mk(0, 0, 0, 32767));
    // lock, negative and positive terms, and yaw wrap
    append_row(mk(23170, 0, -23170, 0));
    append_row(mk(23170, 0, 23170, 0));
    append_row(mk(-20000, 12000, 20000, 12000));
    append_row(mk(-23170, 3000, -23170, -3000));
    // unnormalised, asin saturates
    append_row(mk(32767, 0, 32767, 0));
    append_row(mk(-32768, 0, -32768, 0));
    // tiny threshold: near-zero term on lock path
    t = mk(100, 0, 1, 0); t.set_thr = 1; t.thr = 0; append_row(t);
    append_row(mk(100, 0, 5, 0));
    append_row(mk(1000, 0, -11, 0));
    append_row(mk(0, 0, 0, 0));
    // widest threshold: the extreme row still locks, the next does not
    t = mk(-32768, 0, -32768, 0); t.set_thr = 1; t.thr = 15'h7FFF; append_row(t);
    append_row(mk(23170, 0, 23170, 0));

    lock_thr = LockThrRst;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].set_thr) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
        write_threshold(rows[i].thr);
      end
      if (rows[i].has_exp) begin
        // typed-in value must agree with the predictor too
        if (euler_of(rows[i].w, rows[i].x, rows[i].y, rows[i].z) != rows[i].exp) begin
          errors++;
          $display("%0t: expected %h got predictor %h", $time, rows[i].exp,
                   euler_of(rows[i].w, rows[i].x, rows[i].y, rows[i].z));
        end
      end
      send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z, 1'b1);
    end

    // random phases at several thresholds
    for (int n = 0; n < NRandom; n++) begin
      if (n % 190 == 0) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
        ph = n / 190;
        write_threshold(ph == 0 ? LockThrRst : ph == 1 ? 15'd0 : ph == 2 ? 15'h7FFF :
                        15'($urandom_range(32767)));
      end
      case ($urandom_range(3))
        0: begin  // arbitrary bits
          w = 16'($urandom); x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
        end
        1: begin  // near lock: w ~ +-y, x ~ +-z
          w = 16'($urandom_range(30000) - 15000);
          x = 16'($urandom_range(30000) - 15000);
          y = 16'(($urandom_range(1) ? w : -w) + ($urandom_range(400) - 200));
          z = 16'(($urandom_range(1) ? x : -x) + ($urandom_range(400) - 200));
        end
        default: begin  // moderate, roughly unit-scale components
          w = 16'($urandom_range(46000) - 23000);
          x = 16'($urandom_range(46000) - 23000);
          y = 16'($urandom_range(46000) - 23000);
          z = 16'($urandom_range(46000) - 23000);
        end
      endcase
      send_quat(w, x, y, z, (n % 300) > 60);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
